### sv/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants for the pixel channel converter: pixel
// structs, configuration register indexes, channel layout codes and
// luma weights.
// ----------------------------------------------------------------------------
package pcc_pkg;

  // one input item
  typedef struct packed {
    logic [7:0] in_byte0;
    logic [7:0] in_byte1;
    logic [7:0] in_byte2;
    logic [7:0] in_byte3;
    logic       in_last;
  } in_pix_t;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic       out_last;
  } out_pix_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_CHANNELS   = 2'd1;

  // channel layout codes
  localparam int unsigned CH_W = 3;
  localparam logic [CH_W-1:0] CH_GRAY       = 3'd1;
  localparam logic [CH_W-1:0] CH_GRAY_ALPHA = 3'd2;
  localparam logic [CH_W-1:0] CH_RGB        = 3'd3;
  localparam logic [CH_W-1:0] CH_RGBA       = 3'd4;

  // luma weights and opaque alpha
  localparam logic [7:0] LUMA_R       = 8'd77;
  localparam logic [7:0] LUMA_G       = 8'd150;
  localparam logic [7:0] LUMA_B       = 8'd29;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

endpackage

### sv/pcc_convert.sv
// ----------------------------------------------------------------------------
// pcc_convert
// Combinational channel layout conversion of one pixel: copy, gray
// expansion, luma reduction, alpha fill or carry, zeroing of unused bytes.
// ----------------------------------------------------------------------------
module pcc_convert
  import pcc_pkg::*;
(
  input  in_pix_t         pix_i,
  input  logic [CH_W-1:0] src_ch,
  input  logic [CH_W-1:0] dst_ch,
  output out_pix_t        pix_o
);

  logic        layout_ok;
  logic [15:0] luma_sum;
  logic [7:0]  gray;
  logic [7:0]  alpha;
  logic        src_color;

  // supported layouts are one to four channels
  assign layout_ok = (src_ch inside {[CH_GRAY:CH_RGBA]}) &&
                     (dst_ch inside {[CH_GRAY:CH_RGBA]});

  // weighted sum, max 255*256 so it fits 16 bits
  assign luma_sum = 16'(pix_i.in_byte0) * 16'(LUMA_R) +
                    16'(pix_i.in_byte1) * 16'(LUMA_G) +
                    16'(pix_i.in_byte2) * 16'(LUMA_B);

  assign src_color = (src_ch == CH_RGB) || (src_ch == CH_RGBA);
  assign gray      = src_color ? luma_sum[15:8] : pix_i.in_byte0;

  // source alpha, opaque when the source has none
  always_comb begin
    case (src_ch)
      CH_GRAY_ALPHA: alpha = pix_i.in_byte1;
      CH_RGBA:       alpha = pix_i.in_byte3;
      default:       alpha = ALPHA_OPAQUE;
    endcase
  end

  // output layout selection
  always_comb begin
    pix_o          = '0;
    pix_o.out_last = pix_i.in_last;
    if (layout_ok) begin
      if (src_ch == dst_ch) begin
        pix_o.out_byte0 = pix_i.in_byte0;
        if (dst_ch >= CH_GRAY_ALPHA) pix_o.out_byte1 = pix_i.in_byte1;
        if (dst_ch >= CH_RGB)        pix_o.out_byte2 = pix_i.in_byte2;
        if (dst_ch == CH_RGBA)       pix_o.out_byte3 = pix_i.in_byte3;
      end else if (dst_ch <= CH_GRAY_ALPHA) begin
        pix_o.out_byte0 = gray;
        if (dst_ch == CH_GRAY_ALPHA) pix_o.out_byte1 = alpha;
      end else begin
        pix_o.out_byte0 = pix_i.in_byte0;
        pix_o.out_byte1 = src_color ? pix_i.in_byte1 : pix_i.in_byte0;
        pix_o.out_byte2 = src_color ? pix_i.in_byte2 : pix_i.in_byte0;
        if (dst_ch == CH_RGBA) pix_o.out_byte3 = alpha;
      end
    end
  end

endmodule

### sv/pixel_channel_converter.sv
// ----------------------------------------------------------------------------
// pixel_channel_converter
// Converts one pixel per cycle between gray, gray+alpha, RGB and RGBA
// layouts held in two configuration registers.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+-------------------------
//   input   | start, busy, in_pix            | start & !busy
//   result  | out_valid, out_pix             | strobe, cannot be held
//   config  | cfg_valid, cfg_ready, cfg_*    | cfg_valid & cfg_ready
//
// One item per cycle, from start to out_valid via the input register,
// then the conversion logic (three 8x8 luma products and their sum) into
// the result register. busy is high only during reset and the cycle after
// it. The receiver has no back pressure, so nothing ever stalls. Both
// layout registers reset to RGBA.
// ----------------------------------------------------------------------------
module pixel_channel_converter
  import pcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_pix_t              in_pix,
  output logic                 out_valid,
  output out_pix_t             out_pix,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CH_W-1:0]      cfg_data
);

  logic            busy_r;
  logic            in_valid_r;
  in_pix_t         in_pix_r;
  logic            out_valid_r;
  out_pix_t        out_pix_r;
  out_pix_t        out_pix_nxt;
  logic [CH_W-1:0] src_ch_r;
  logic [CH_W-1:0] dst_ch_r;
  logic            in_take;

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;
  assign in_take   = start && !busy_r;

  // ready flag, held off through reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_ch_r <= CH_RGBA;
      dst_ch_r <= CH_RGBA;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SOURCE_CHANNELS: src_ch_r <= cfg_data;
        CFG_DEST_CHANNELS:   dst_ch_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_pix_r <= in_pix;
    end
  end

  // conversion logic
  pcc_convert u_convert (
    .pix_i  (in_pix_r),
    .src_ch (src_ch_r),
    .dst_ch (dst_ch_r),
    .pix_o  (out_pix_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_pix_r <= out_pix_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;

  // checks
  a_take_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_valid_r)
    else $error("accepted item did not reach the input register");

  a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |=> out_valid_r)
    else $error("staged item did not produce a result");

  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pix_r.out_last == $past(in_pix.in_last, 2))
    else $error("last flag does not match the accepted item");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !in_valid_r && busy_r)
    else $error("pipeline not cleared by reset");

endmodule

### tb/pixel_channel_converter_test.sv
// ----------------------------------------------------------------------------
// pixel_channel_converter_test
// Self-checking testbench for the pixel channel converter. Pixels go in
// through the start/busy command port, results are checked field by field
// against a software conversion of each accepted item, and the layout
// registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module pixel_channel_converter_test;
  import pcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // layout codes outside the supported range, and an index with no register
  localparam logic [CH_W-1:0]      CH_NONE        = 3'd0;
  localparam logic [CH_W-1:0]      CH_TOP_CODE    = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 100000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_pix_t              in_pix = '0;
  logic                 out_valid;
  out_pix_t             out_pix;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CH_W-1:0]      cfg_data = '0;

  // mirror of the layout registers
  logic [CH_W-1:0] src_layout = CH_RGBA;
  logic [CH_W-1:0] dst_layout = CH_RGBA;

  out_pix_t expected_pix[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  bit       idle_on = 1'b1;
  int       pixels_left = 1;

  pixel_channel_converter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pix    (in_pix),
    .out_valid (out_valid),
    .out_pix   (out_pix),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // expected pixel for a given layout pair
  function automatic out_pix_t convert_pixel(input in_pix_t p, input logic [CH_W-1:0] src,
                                             input logic [CH_W-1:0] dst);
    out_pix_t    r;
    logic [17:0] luma_sum;
    logic [7:0]  gray;
    logic [7:0]  alpha;
    r = '0;
    r.out_last = p.in_last;
    if (src >= CH_GRAY && src <= CH_RGBA && dst >= CH_GRAY && dst <= CH_RGBA) begin
      luma_sum = 18'(p.in_byte0) * LUMA_R + 18'(p.in_byte1) * LUMA_G
               + 18'(p.in_byte2) * LUMA_B;
      gray  = (src >= CH_RGB) ? luma_sum[15:8] : p.in_byte0;
      alpha = (src == CH_GRAY_ALPHA) ? p.in_byte1 :
              (src == CH_RGBA) ? p.in_byte3 : ALPHA_OPAQUE;
      if (src == dst) begin
        // straight copy of the used bytes
        r.out_byte0 = p.in_byte0;
        if (dst >= CH_GRAY_ALPHA) r.out_byte1 = p.in_byte1;
        if (dst >= CH_RGB) r.out_byte2 = p.in_byte2;
        if (dst == CH_RGBA) r.out_byte3 = p.in_byte3;
      end else if (dst <= CH_GRAY_ALPHA) begin
        r.out_byte0 = gray;
        if (dst == CH_GRAY_ALPHA) r.out_byte1 = alpha;
      end else begin
        // color out: color bytes are copied, gray is replicated into r, g and b
        if (src >= CH_RGB) begin
          r.out_byte0 = p.in_byte0;
          r.out_byte1 = p.in_byte1;
          r.out_byte2 = p.in_byte2;
        end else begin
          r.out_byte0 = p.in_byte0;
          r.out_byte1 = p.in_byte0;
          r.out_byte2 = p.in_byte0;
        end
        if (dst == CH_RGBA) r.out_byte3 = alpha;
      end
    end
    return r;
  endfunction

  // byte with extra weight on the extremes
  function automatic logic [7:0] random_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // next pixel of the current image, last set on its final pixel
  function automatic in_pix_t next_pixel();
    in_pix_t p;
    p.in_byte0 = random_byte();
    p.in_byte1 = random_byte();
    p.in_byte2 = random_byte();
    p.in_byte3 = random_byte();
    pixels_left--;
    p.in_last = (pixels_left == 0);
    if (pixels_left == 0) pixels_left = $urandom_range(1, 40);
    return p;
  endfunction

  // mostly supported layouts, now and then any code
  function automatic logic [CH_W-1:0] random_layout();
    if ($urandom_range(9) == 0) return CH_W'($urandom_range(CH_TOP_CODE));
    return CH_W'($urandom_range(CH_RGBA, CH_GRAY));
  endfunction

  // send one item, with an optional idle gap in front
  task automatic send_pixel(input in_pix_t pix);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(99) < 30) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_pix <= pix;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_pix.push_back(convert_pixel(pix, src_layout, dst_layout));
  endtask

  // stop sending and wait until every result is back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_pix.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write, cfg_valid left high for the caller to lower
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CH_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_SOURCE_CHANNELS) src_layout = data;
    else if (idx == CFG_DEST_CHANNELS) dst_layout = data;
  endtask

  task automatic set_layout(input logic [CH_W-1:0] src, input logic [CH_W-1:0] dst);
    wait_drained();
    write_reg(CFG_SOURCE_CHANNELS, src);
    write_reg(CFG_DEST_CHANNELS, dst);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // reset layout is rgba to rgba, field extremes
  task automatic test_reset_layout();
    send_pixel('0);
    send_pixel('1);
  endtask

  // one pixel through every source and destination pair
  task automatic test_all_conversions();
    in_pix_t p;
    for (int s = CH_GRAY; s <= CH_RGBA; s++) begin
      for (int d = CH_GRAY; d <= CH_RGBA; d++) begin
        set_layout(CH_W'(s), CH_W'(d));
        p = next_pixel();
        send_pixel(p);
      end
    end
    // brightest color gives the largest luma
    set_layout(CH_RGB, CH_GRAY);
    send_pixel('1);
  endtask

  // unsupported codes zero the bytes, a write to a missing register changes nothing
  task automatic test_unsupported_layouts();
    set_layout(CH_NONE, CH_RGBA);
    send_pixel(next_pixel());
    set_layout(CH_RGB, CH_TOP_CODE);
    send_pixel(next_pixel());
    wait_drained();
    write_reg(CFG_UNUSED_IDX, CH_TOP_CODE);
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_pixel(next_pixel());
  endtask

  // back to back items with no idling at all
  task automatic test_full_rate_burst();
    idle_on = 1'b0;
    set_layout(CH_RGBA, CH_GRAY_ALPHA);
    repeat (150) send_pixel(next_pixel());
    idle_on = 1'b1;
  endtask

  // random phases of random layouts, with an occasional full pause
  task automatic test_random_phases();
    int sent;
    int phase_len;
    sent = 0;
    while (sent < 700) begin
      set_layout(random_layout(), random_layout());
      phase_len = $urandom_range(10, 60);
      repeat (phase_len) begin
        send_pixel(next_pixel());
        sent++;
        if ($urandom_range(39) == 0) wait_drained();
      end
    end
  endtask

  // result checker
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_pix_t want;
    if (rst_n && out_valid) begin
      if (expected_pix.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_pix);
        mismatch_count++;
      end else begin
        want = expected_pix.pop_front();
        check_field("out_byte0", want.out_byte0, out_pix.out_byte0);
        check_field("out_byte1", want.out_byte1, out_pix.out_byte1);
        check_field("out_byte2", want.out_byte2, out_pix.out_byte2);
        check_field("out_byte3", want.out_byte3, out_pix.out_byte3);
        check_field("out_last", 8'(want.out_last), 8'(out_pix.out_last));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    pixels_left = $urandom_range(1, 40);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_layout();
    test_all_conversions();
    test_unsupported_layouts();
    test_full_rate_burst();
    test_random_phases();
    wait_drained();
    if (mismatch_count == 0 && expected_pix.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
